/* sv/variant_header_byte_parser_unit_defines.svh */
// Assertion macros used by the checker of the variant header parser.
`ifndef VARIANT_HEADER_BYTE_PARSER_UNIT_DEFINES_SVH
`define VARIANT_HEADER_BYTE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VHBP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vhbp check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VHBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vhbp check failed");

`endif

/* sv/vhbp_pkg.sv */
package vhbp_pkg;

	// Parse phases
	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_NSAMP      = 4'd1;
	localparam logic [3:0] PH_VARID_LEN  = 4'd2;
	localparam logic [3:0] PH_VARID      = 4'd3;
	localparam logic [3:0] PH_RSID_LEN   = 4'd4;
	localparam logic [3:0] PH_RSID       = 4'd5;
	localparam logic [3:0] PH_CHROM_LEN  = 4'd6;
	localparam logic [3:0] PH_CHROM      = 4'd7;
	localparam logic [3:0] PH_POS        = 4'd8;
	localparam logic [3:0] PH_NALL       = 4'd9;
	localparam logic [3:0] PH_ALLELE_LEN = 4'd10;
	localparam logic [3:0] PH_ALLELE     = 4'd11;
	localparam logic [3:0] PH_GLEN       = 4'd12;

	// Result kinds
	localparam logic [3:0] K_VARID  = 4'd0;
	localparam logic [3:0] K_RSID   = 4'd1;
	localparam logic [3:0] K_CHROM  = 4'd2;
	localparam logic [3:0] K_ALLELE = 4'd3;
	localparam logic [3:0] K_POS    = 4'd4;
	localparam logic [3:0] K_NALL   = 4'd5;
	localparam logic [3:0] K_DONE   = 4'd6;
	localparam logic [3:0] K_ERR    = 4'd7;
	localparam logic [3:0] K_NSAMP  = 4'd8;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_EARLY    = 2'd1;
	localparam logic [1:0] ERR_MISMATCH = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_LAYOUT   = 2'd0;
	localparam logic [1:0] REG_COMP     = 2'd1;
	localparam logic [1:0] REG_EXPECTED = 2'd2;

	// Result tdata layout, lowest bit first
	localparam int VALUE_LSB  = 0;
	localparam int ALLELE_LSB = 32;
	localparam int OFF_LSB    = 48;
	localparam int TOT_LSB    = 80;
	localparam int ERR_LSB    = 113;
	localparam int TDATA_W    = 120;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [15:0] allele_number;
		logic [31:0] gt_offset;
		logic [32:0] block_size;
		logic [1:0]  error_code;
		logic        last_result;
	} res_t;

	function automatic res_t mk_res(
		input logic [3:0]  kind,
		input logic [31:0] value,
		input logic [15:0] allele,
		input logic [31:0] off,
		input logic [32:0] tot,
		input logic [1:0]  err
	);
		res_t r;
		r.kind          = kind;
		r.value         = value;
		r.allele_number = allele;
		r.gt_offset     = off;
		r.block_size    = tot;
		r.error_code    = err;
		r.last_result   = 1'b0;
		return r;
	endfunction

endpackage

/* sv/variant_header_byte_parser_unit.sv */
// Variant header byte parser. Takes the bytes of one variant block, one byte per
// s_tdata transfer (s_tuser = first byte of a block, s_tlast = last byte in the
// buffer), and walks the header fields little-endian: the layout 1.1 sample count,
// the varid, rsid and chromosome strings, the position, the allele count and the
// alleles, then the genotype length. String bytes come out tagged by field, the
// sample count, position and allele count when their last byte arrives, and a
// done result carries the genotype offset and the total block size. Rate: one
// byte per cycle. Each byte gives zero, one or two results into a four-entry
// result queue that drains one result per cycle on the master side; s_tready
// drops only while fewer than two queue slots are free, so a steady stream
// stalls only when the consumer stalls or bytes giving two results arrive back
// to back. Configuration registers are written through cfg_we / cfg_addr /
// cfg_wdata and take effect on the next byte.
module variant_header_byte_parser_unit
	import vhbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	// byte input
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [7:0] data_byte
	input  logic [0:0]         s_tuser,    // [0] first_byte
	input  logic               s_tlast,    // last_byte
	// result output
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,    // value[31:0], allele_number[47:32],
	                                       // gt_offset[79:48],
	                                       // block_size[112:80], error_code[114:113],
	                                       // zero pad [119:115]
	output logic [3:0]         m_tuser,    // [3:0] kind
	output logic               m_tlast     // last_result
);

	// configuration
	logic        layout_q;
	logic        comp_q;
	logic [31:0] expected_q;

	// parser state
	logic [3:0]  phase_q;
	logic [1:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] left_q;
	logic [15:0] atot_q;
	logic [15:0] aidx_q;
	logic [31:0] pos_q;
	logic [31:0] nsamp_q;

	// working copies for the byte being parsed
	logic [3:0]  phase_d;
	logic [1:0]  cnt_d;
	logic [31:0] acc_d;
	logic [31:0] left_d;
	logic [15:0] atot_d;
	logic [15:0] aidx_d;
	logic [31:0] pos_d;
	logic [31:0] nsamp_d;
	logic [31:0] fval;
	logic [31:0] glen6;
	logic        fdone;
	logic        go_after;
	logic [1:0]  nres;
	res_t        res [2];

	// result queue
	res_t        q_mem [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	logic in_fire;
	logic out_fire;
	logic first;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign first    = s_tuser[0];

	// accept a byte only while two result slots are free
	assign s_tready = (count_q <= 3'd2);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		left_d   = left_q;
		atot_d   = atot_q;
		aidx_d   = aidx_q;
		pos_d    = pos_q;
		nsamp_d  = nsamp_q;
		fval     = 32'd0;
		glen6    = 32'd0;
		fdone    = 1'b0;
		go_after = 1'b0;
		nres     = 2'd0;
		res[0]   = '0;
		res[1]   = '0;

		if (in_fire && (first || phase_q != PH_IDLE)) begin
			// a first byte restarts the block from clean state
			if (first) begin
				phase_d = layout_q ? PH_VARID_LEN : PH_NSAMP;
				cnt_d   = 2'd0;
				acc_d   = 32'd0;
				left_d  = 32'd0;
				atot_d  = 16'd0;
				aidx_d  = 16'd0;
				pos_d   = 32'd0;
				nsamp_d = 32'd0;
			end

			// saturating byte count
			if (pos_d != 32'hFFFF_FFFF) begin
				pos_d = pos_d + 32'd1;
			end

			if (phase_d inside {PH_VARID, PH_RSID, PH_CHROM, PH_ALLELE}) begin
				// pass the string byte through, tagged by field
				case (phase_d)
					PH_VARID: res[0] = mk_res(K_VARID, {24'd0, s_tdata}, 16'd0,
						32'd0, 33'd0, ERR_NONE);
					PH_RSID: res[0] = mk_res(K_RSID, {24'd0, s_tdata}, 16'd0,
						32'd0, 33'd0, ERR_NONE);
					PH_CHROM: res[0] = mk_res(K_CHROM, {24'd0, s_tdata}, 16'd0,
						32'd0, 33'd0, ERR_NONE);
					default: res[0] = mk_res(K_ALLELE, {24'd0, s_tdata}, aidx_d,
						32'd0, 33'd0, ERR_NONE);
				endcase
				nres   = 2'd1;
				left_d = left_d - 32'd1;
				if (left_d == 32'd0) begin
					case (phase_d)
						PH_ALLELE: begin
							aidx_d = aidx_d + 16'd1;
							if (aidx_d < atot_d) begin
								phase_d = PH_ALLELE_LEN;
							end else begin
								go_after = 1'b1;
							end
						end
						PH_CHROM: phase_d = PH_POS;
						default:  phase_d = phase_d + 4'd1;
					endcase
				end
			end else begin
				// gather a little-endian numeric field
				fval = acc_d | ({24'd0, s_tdata} << {cnt_d, 3'b000});
				if (phase_d inside {PH_VARID_LEN, PH_RSID_LEN, PH_CHROM_LEN, PH_NALL}) begin
					fdone = (cnt_d == 2'd1);
				end else begin
					fdone = (cnt_d == 2'd3);
				end

				if (!fdone) begin
					acc_d = fval;
					cnt_d = cnt_d + 2'd1;
				end else begin
					acc_d = 32'd0;
					cnt_d = 2'd0;
					case (phase_d)
						PH_NSAMP: begin
							nsamp_d = fval;
							res[0]  = mk_res(K_NSAMP, fval, 16'd0, 32'd0, 33'd0,
								ERR_NONE);
							nres    = 2'd1;
							if (fval != expected_q) begin
								res[1]  = mk_res(K_ERR, 32'd0, 16'd0, 32'd0, 33'd0,
									ERR_MISMATCH);
								nres    = 2'd2;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_VARID_LEN;
							end
						end
						PH_VARID_LEN, PH_RSID_LEN: begin
							left_d  = fval;
							// zero length skips the string
							phase_d = (fval != 32'd0) ? phase_d + 4'd1 : phase_d + 4'd2;
						end
						PH_CHROM_LEN: begin
							left_d  = fval;
							phase_d = (fval != 32'd0) ? PH_CHROM : PH_POS;
						end
						PH_POS: begin
							res[0] = mk_res(K_POS, fval, 16'd0, 32'd0, 33'd0, ERR_NONE);
							nres   = 2'd1;
							if (!layout_q) begin
								// layout 1.1 carries two alleles implicitly
								atot_d  = 16'd2;
								aidx_d  = 16'd0;
								res[1]  = mk_res(K_NALL, 32'd2, 16'd0, 32'd0, 33'd0,
									ERR_NONE);
								nres    = 2'd2;
								phase_d = PH_ALLELE_LEN;
							end else begin
								phase_d = PH_NALL;
							end
						end
						PH_NALL: begin
							atot_d = fval[15:0];
							aidx_d = 16'd0;
							res[0] = mk_res(K_NALL, {16'd0, fval[15:0]}, 16'd0, 32'd0,
								33'd0, ERR_NONE);
							nres   = 2'd1;
							if (fval[15:0] == 16'd0) begin
								go_after = 1'b1;
							end else begin
								phase_d = PH_ALLELE_LEN;
							end
						end
						PH_ALLELE_LEN: begin
							left_d = fval;
							if (fval != 32'd0) begin
								phase_d = PH_ALLELE;
							end else begin
								aidx_d = aidx_d + 16'd1;
								if (aidx_d < atot_d) begin
									phase_d = PH_ALLELE_LEN;
								end else begin
									go_after = 1'b1;
								end
							end
						end
						default: begin
							// genotype length read from the block
							res[0]  = mk_res(K_DONE, fval, 16'd0, pos_d,
								{1'b0, pos_d} + {1'b0, fval}, ERR_NONE);
							nres    = 2'd1;
							phase_d = PH_IDLE;
						end
					endcase
				end
			end

			// after the last allele: uncompressed layout 1.1 finishes here
			if (go_after) begin
				if (!layout_q && !comp_q) begin
					glen6 = {nsamp_d[29:0], 2'b00} + {nsamp_d[30:0], 1'b0};
					res[nres[0]] = mk_res(K_DONE, glen6, 16'd0, pos_d,
						{1'b0, pos_d} + {1'b0, glen6}, ERR_NONE);
					nres    = nres + 2'd1;
					phase_d = PH_IDLE;
				end else begin
					phase_d = PH_GLEN;
				end
			end

			// buffer ended inside the header: replace everything by one error
			if (s_tlast && phase_d != PH_IDLE) begin
				res[0]  = mk_res(K_ERR, 32'd0, 16'd0, 32'd0, 33'd0, ERR_EARLY);
				nres    = 2'd1;
				phase_d = PH_IDLE;
			end

			if (nres != 2'd0) begin
				res[nres[1]].last_result = 1'b1;
			end
		end
	end

	// configuration and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q   <= 1'b1;
			comp_q     <= 1'b1;
			expected_q <= 32'd0;
			phase_q    <= PH_IDLE;
			cnt_q      <= 2'd0;
			acc_q      <= 32'd0;
			left_q     <= 32'd0;
			atot_q     <= 16'd0;
			aidx_q     <= 16'd0;
			pos_q      <= 32'd0;
			nsamp_q    <= 32'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LAYOUT:   layout_q   <= cfg_wdata[0];
					REG_COMP:     comp_q     <= cfg_wdata[0];
					REG_EXPECTED: expected_q <= cfg_wdata;
					default: ; // drop writes beyond the register list
				endcase
			end
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			atot_q  <= atot_d;
			aidx_q  <= aidx_d;
			pos_q   <= pos_d;
			nsamp_q <= nsamp_d;
		end
	end

	// result queue payload: up to two writes, one read per cycle
	always_ff @(posedge clk) begin
		if (nres != 2'd0) begin
			q_mem[wr_ptr_q] <= res[0];
		end
		if (nres == 2'd2) begin
			q_mem[wr_ptr_q + 2'd1] <= res[1];
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + nres;
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, nres} - {2'd0, out_fire};
		end
	end

	assign m_tvalid = (count_q != 3'd0);
	assign m_tuser  = q_mem[rd_ptr_q].kind;
	assign m_tlast  = q_mem[rd_ptr_q].last_result;
	assign m_tdata  = {5'd0,
		q_mem[rd_ptr_q].error_code,
		q_mem[rd_ptr_q].block_size,
		q_mem[rd_ptr_q].gt_offset,
		q_mem[rd_ptr_q].allele_number,
		q_mem[rd_ptr_q].value};

endmodule

/* sv/vhbp_checker.sv */
`include "variant_header_byte_parser_unit_defines.svh"

module vhbp_checker
	import vhbp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [3:0]         m_tuser,
	input logic               m_tlast
);

	logic [31:0] value;
	logic [31:0] off;
	logic [32:0] tot;
	logic [1:0]  err;

	assign value = m_tdata[VALUE_LSB +: 32];
	assign off   = m_tdata[OFF_LSB +: 32];
	assign tot   = m_tdata[TOT_LSB +: 33];
	assign err   = m_tdata[ERR_LSB +: 2];

	// hold a stalled result
	`VHBP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// done size is offset plus genotype length
	`VHBP_ASSERT_NOW(a_done_size, m_tvalid && m_tuser == K_DONE, tot == ({1'b0, off} + {1'b0, value}) && m_tlast)

	// an error ends the byte's results and carries a real code
	`VHBP_ASSERT_NOW(a_err_code, m_tvalid && m_tuser == K_ERR, m_tlast && value == 32'd0 && (err == ERR_EARLY || err == ERR_MISMATCH))

	// only done carries offset and size
	`VHBP_ASSERT_NOW(a_off_zero, m_tvalid && m_tuser != K_DONE, off == 32'd0 && tot == 33'd0)

endmodule

bind variant_header_byte_parser_unit vhbp_checker u_vhbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* bench/variant_header_byte_parser_unit_test.sv */
`timescale 1ns / 1ps

module variant_header_byte_parser_unit_test
	import vhbp_pkg::*;
();

	// Directed table rows: either one byte transfer or one register write
	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_REG
	} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [7:0]  data;
		logic        start_flag;
		logic        end_flag;
		logic        chk;        // typed expectation present
		int          n;          // results this byte must cause
		logic [3:0]  kind;       // kind of its final result
		logic [31:0] value;      // value of its final result, or register data
		logic [1:0]  code;       // error code of its final result
		logic [1:0]  idx;        // register index
	} stim_row_t;

	// DUT-facing signals, the ones driven here known from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_addr  = REG_LAYOUT;
	logic [31:0]        cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = '0;
	logic [0:0]         s_tuser   = '0;
	logic               s_tlast   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [3:0]         m_tuser;
	logic               m_tlast;

	// Idle rates in percent, changed per stimulus phase
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;

	// Header parser model: register copies and parse state, reset values
	logic        cfg_layout   = 1'b1;
	logic        cfg_comp     = 1'b1;
	logic [31:0] cfg_expected = '0;
	logic [3:0]  hdr_phase    = PH_IDLE;
	logic [2:0]  num_bytes    = '0;
	logic [31:0] num_acc      = '0;
	logic [31:0] str_left     = '0;
	logic [15:0] allele_total = '0;
	logic [15:0] allele_idx   = '0;
	logic [31:0] byte_pos     = '0;
	logic [31:0] samples_seen = '0;

	res_t step_results[$];     // results of the byte just parsed
	res_t expected_fields[$];  // results still owed by the DUT, oldest first

	logic [7:0] block_bytes[$];
	stim_row_t  directed_rows[$];

	int bytes_sent     = 0;
	int blocks_sent    = 0;
	int results_checked = 0;
	int reg_writes     = 0;
	int mismatches     = 0;

	variant_header_byte_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [7:0] data_byte
		.s_tuser   (s_tuser),    // [0] first_byte
		.s_tlast   (s_tlast),    // last_byte
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // value, allele_number, gt_offset, block_size,
		                         // error_code
		.m_tuser   (m_tuser),    // [3:0] kind
		.m_tlast   (m_tlast)     // last_result
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the DUT wedges or drops results
	initial begin
		#5_000_000;
		$display("variant_header_byte_parser_unit_test: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Header parser model
	// ------------------------------------------------------------------

	task automatic add_result(input logic [3:0] kind, input logic [31:0] value,
			input logic [15:0] allele, input logic [31:0] off, input logic [32:0] tot,
			input logic [1:0] code);
		res_t r;
		r = '0;
		r.kind          = kind;
		r.value         = value;
		r.allele_number = allele;
		r.gt_offset     = off;
		r.block_size    = tot;
		r.error_code    = code;
		step_results.insert(step_results.size(), r);
	endtask

	// Header complete: report where genotype data starts and how big the block is
	task automatic close_header(input logic [31:0] glen);
		add_result(K_DONE, glen, 16'd0, byte_pos, {1'b0, byte_pos} + {1'b0, glen}, ERR_NONE);
		hdr_phase = PH_IDLE;
	endtask

	// Layout 1.1 uncompressed has no length field: six bytes per sample, mod 2^32
	task automatic alleles_finished();
		logic [31:0] glen;
		if (!cfg_layout && !cfg_comp) begin
			glen = samples_seen * 32'd6;
			close_header(glen);
		end else begin
			hdr_phase = PH_GLEN;
		end
	endtask

	task automatic advance_allele();
		allele_idx = allele_idx + 16'd1;
		if (allele_idx < allele_total) begin
			hdr_phase = PH_ALLELE_LEN;
		end else begin
			alleles_finished();
		end
	endtask

	task automatic begin_alleles();
		allele_idx = '0;
		if (allele_total == 16'd0) begin
			alleles_finished();
		end else begin
			hdr_phase = PH_ALLELE_LEN;
		end
	endtask

	// A zero length skips the string; after chromosome comes the position
	task automatic take_length(input logic [31:0] len, input logic [3:0] data_phase);
		str_left = len;
		if (len != 0) begin
			hdr_phase = data_phase;
		end else if (data_phase == PH_CHROM) begin
			hdr_phase = PH_POS;
		end else begin
			hdr_phase = data_phase + 4'd1;
		end
	endtask

	// Advance the model by one accepted byte; queue the results it owes
	task automatic parse_header_byte(input logic [7:0] b, input logic start_flag,
			input logic end_flag);
		logic [31:0] word;
		logic [2:0]  width;
		logic [3:0]  tag;
		step_results.delete();
		if (start_flag) begin
			hdr_phase    = cfg_layout ? PH_VARID_LEN : PH_NSAMP;
			num_bytes    = '0;
			num_acc      = '0;
			str_left     = '0;
			allele_total = '0;
			allele_idx   = '0;
			byte_pos     = '0;
			samples_seen = '0;
		end else if (hdr_phase == PH_IDLE) begin
			return;
		end
		if (byte_pos != 32'hFFFF_FFFF)
			byte_pos = byte_pos + 32'd1;

		case (hdr_phase)
			PH_VARID, PH_RSID, PH_CHROM, PH_ALLELE: begin
				case (hdr_phase)
					PH_VARID: tag = K_VARID;
					PH_RSID:  tag = K_RSID;
					PH_CHROM: tag = K_CHROM;
					default:  tag = K_ALLELE;
				endcase
				add_result(tag, {24'd0, b}, (tag == K_ALLELE) ? allele_idx : 16'd0,
					32'd0, 33'd0, ERR_NONE);
				str_left = str_left - 32'd1;
				if (str_left == 0) begin
					if (hdr_phase == PH_ALLELE) begin
						advance_allele();
					end else if (hdr_phase == PH_CHROM) begin
						hdr_phase = PH_POS;
					end else begin
						hdr_phase = hdr_phase + 4'd1;
					end
				end
			end
			default: begin
				// little-endian numeric field: collect, then act on the full word
				num_acc   = num_acc | ({24'd0, b} << (8 * num_bytes[1:0]));
				num_bytes = num_bytes + 3'd1;
				width = (hdr_phase == PH_VARID_LEN || hdr_phase == PH_RSID_LEN ||
					hdr_phase == PH_CHROM_LEN || hdr_phase == PH_NALL) ? 3'd2 : 3'd4;
				if (num_bytes >= width) begin
					word      = num_acc;
					num_acc   = '0;
					num_bytes = '0;
					case (hdr_phase)
						PH_NSAMP: begin
							samples_seen = word;
							add_result(K_NSAMP, word, 16'd0, 32'd0, 33'd0, ERR_NONE);
							if (word != cfg_expected) begin
								add_result(K_ERR, 32'd0, 16'd0, 32'd0, 33'd0, ERR_MISMATCH);
								hdr_phase = PH_IDLE;
							end else begin
								hdr_phase = PH_VARID_LEN;
							end
						end
						PH_VARID_LEN: take_length(word, PH_VARID);
						PH_RSID_LEN:  take_length(word, PH_RSID);
						PH_CHROM_LEN: take_length(word, PH_CHROM);
						PH_POS: begin
							add_result(K_POS, word, 16'd0, 32'd0, 33'd0, ERR_NONE);
							if (!cfg_layout) begin
								// layout 1.1 has no count field: always two alleles
								allele_total = 16'd2;
								add_result(K_NALL, 32'd2, 16'd0, 32'd0, 33'd0, ERR_NONE);
								begin_alleles();
							end else begin
								hdr_phase = PH_NALL;
							end
						end
						PH_NALL: begin
							allele_total = word[15:0];
							add_result(K_NALL, {16'd0, word[15:0]}, 16'd0, 32'd0, 33'd0,
								ERR_NONE);
							begin_alleles();
						end
						PH_ALLELE_LEN: begin
							str_left = word;
							if (word != 0) begin
								hdr_phase = PH_ALLELE;
							end else begin
								advance_allele();
							end
						end
						default: close_header(word);
					endcase
				end
			end
		endcase

		// Buffer ran out inside the header: one early-end error replaces all else
		if (end_flag && hdr_phase != PH_IDLE) begin
			step_results.delete();
			add_result(K_ERR, 32'd0, 16'd0, 32'd0, 33'd0, ERR_EARLY);
			hdr_phase = PH_IDLE;
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last_result = 1'b1;
		foreach (step_results[i])
			expected_fields.insert(expected_fields.size(), step_results[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus side
	// ------------------------------------------------------------------

	// Enter right after a rising edge; return right after the edge of the transfer
	task automatic send_byte(input logic [7:0] b, input logic start_flag,
			input logic end_flag);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start_flag;
		s_tlast  <= end_flag;
		// inputs are steady from the falling edge on, so ready seen there holds
		@(negedge clk);
		while (s_tready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
		parse_header_byte(b, start_flag, end_flag);
		bytes_sent++;
	endtask

	// Hold off input until every owed result is out, then let the pipe settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_LAYOUT: cfg_layout   = val[0];
			REG_COMP:   cfg_comp     = val[0];
			default:    cfg_expected = val;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	function automatic stim_row_t byte_row(input logic [7:0] b, input logic sf,
			input logic ef);
		stim_row_t r;
		r = '{op: ROW_BYTE, data: b, start_flag: sf, end_flag: ef, chk: 1'b0, n: 0,
			kind: K_VARID, value: 32'd0, code: ERR_NONE, idx: REG_LAYOUT};
		return r;
	endfunction

	function automatic stim_row_t chk_row(input logic [7:0] b, input logic sf,
			input logic ef, input int n, input logic [3:0] kind, input logic [31:0] value,
			input logic [1:0] code);
		stim_row_t r;
		r = byte_row(b, sf, ef);
		r.chk   = 1'b1;
		r.n     = n;
		r.kind  = kind;
		r.value = value;
		r.code  = code;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
		stim_row_t r;
		r = byte_row(8'd0, 1'b0, 1'b0);
		r.op    = ROW_REG;
		r.idx   = idx;
		r.value = val;
		return r;
	endfunction

	// Append one row to the directed table
	task automatic add_row(input stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endtask

	function automatic int short_length();
		return ($urandom_range(9) == 0) ? 7 : int'($urandom_range(3));
	endfunction

	task automatic append_le(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			block_bytes.insert(block_bytes.size(), v[8 * i +: 8]);
	endtask

	// Length prefix of the given width, then that many random bytes
	task automatic append_string(input int len, input int prefix_bytes);
		append_le(len, prefix_bytes);
		for (int i = 0; i < len; i++)
			block_bytes.insert(block_bytes.size(), 8'($urandom()));
	endtask

	// One block for the current registers: mostly well formed, some cut short
	// (with or without the end flag), a few pure noise
	task automatic send_block(output int counted);
		int          shape;
		int          cut;
		int          alleles;
		logic [31:0] word;
		block_bytes.delete();
		if (!cfg_layout) begin
			word = ($urandom_range(99) < 85) ? cfg_expected : $urandom();
			append_le(word, 4);
		end
		repeat (3) append_string(short_length(), 2);
		if ($urandom_range(9) == 0) begin
			word = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'd0;
		end else begin
			word = $urandom();
		end
		append_le(word, 4);
		if (cfg_layout) begin
			alleles = int'($urandom_range(3));
			append_le(alleles, 2);
		end else begin
			alleles = 2;
		end
		repeat (alleles) append_string(short_length(), 4);
		if (cfg_layout || !cfg_comp == 1'b0)
			append_le($urandom(), 4);

		shape   = int'($urandom_range(99));
		counted = 0;
		if (shape < 80) begin
			for (int i = 0; i < block_bytes.size(); i++)
				send_byte(block_bytes[i], i == 0,
					i == block_bytes.size() - 1 && $urandom_range(1) == 1);
			counted = block_bytes.size();
			// trailing bytes land while idle and are dropped
			repeat ($urandom_range(2))
				send_byte(8'($urandom()), 1'b0, $urandom_range(3) == 0);
		end else if (shape < 95) begin
			cut = int'($urandom_range(block_bytes.size() - 1));
			for (int i = 0; i <= cut; i++)
				send_byte(block_bytes[i], i == 0, i == cut && shape < 90);
			counted = cut + 1;
		end else begin
			cut = int'($urandom_range(8, 1));
			for (int i = 0; i < cut; i++)
				send_byte(8'($urandom()),
					(i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(7) == 0),
					$urandom_range(7) == 0);
			counted = cut;
		end
		blocks_sent++;
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Consumer stalls at the current rate
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);

	task automatic check_field(input string what, input logic [32:0] want,
			input logic [32:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Outputs are steady at the falling edge; a transfer seen there completes
	// at the next rising edge
	always @(negedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_fields.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h tdata %0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_fields.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("value", want.value, m_tdata[VALUE_LSB +: 32]);
				check_field("allele_number", want.allele_number, m_tdata[ALLELE_LSB +: 16]);
				check_field("gt_offset", want.gt_offset, m_tdata[OFF_LSB +: 32]);
				check_field("block_size", want.block_size, m_tdata[TOT_LSB +: 33]);
				check_field("error_code", want.error_code, m_tdata[ERR_LSB +: 2]);
				check_field("last_result", want.last_result, m_tlast);
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin : run
		stim_row_t   row;
		res_t        tail;
		int          counted;
		int          phase_count;
		int          guard;
		logic        lay;
		logic        comp;
		logic [31:0] samples;

		// Directed table, registers at reset: layout 1.2, compressed, no samples
		add_row(chk_row(8'hA5, 1'b0, 1'b0, 0, K_VARID, 32'd0, ERR_NONE));
		add_row(byte_row(8'h01, 1'b1, 1'b0));           // varid length 1
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(chk_row(8'hFF, 1'b0, 1'b0, 1, K_VARID, 32'hFF, ERR_NONE));
		add_row(byte_row(8'h00, 1'b0, 1'b0));           // empty rsid
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(byte_row(8'h00, 1'b0, 1'b0));           // empty chromosome
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(byte_row(8'hFF, 1'b0, 1'b0));           // position all ones
		add_row(byte_row(8'hFF, 1'b0, 1'b0));
		add_row(byte_row(8'hFF, 1'b0, 1'b0));
		add_row(chk_row(8'hFF, 1'b0, 1'b0, 1, K_POS, 32'hFFFF_FFFF, ERR_NONE));
		add_row(byte_row(8'h00, 1'b0, 1'b0));           // no alleles at all
		add_row(chk_row(8'h00, 1'b0, 1'b0, 1, K_NALL, 32'd0, ERR_NONE));
		add_row(byte_row(8'hFF, 1'b0, 1'b0));           // genotype length max
		add_row(byte_row(8'hFF, 1'b0, 1'b0));
		add_row(byte_row(8'hFF, 1'b0, 1'b0));
		add_row(chk_row(8'hFF, 1'b0, 1'b0, 1, K_DONE, 32'hFFFF_FFFF, ERR_NONE));
		add_row(chk_row(8'h00, 1'b0, 1'b0, 0, K_VARID, 32'd0, ERR_NONE));
		// start and end on the same byte: header cut off at once
		add_row(chk_row(8'h00, 1'b1, 1'b1, 1, K_ERR, 32'd0, ERR_EARLY));
		// restart in the middle of a length field drops the partial header
		add_row(byte_row(8'h07, 1'b1, 1'b0));
		add_row(byte_row(8'h00, 1'b1, 1'b0));
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(chk_row(8'h00, 1'b0, 1'b1, 1, K_ERR, 32'd0, ERR_EARLY));
		// layout 1.1: a count that misses the expected one wins over the end flag
		add_row(reg_row(REG_LAYOUT, 32'd0));
		add_row(reg_row(REG_EXPECTED, 32'hFFFF_FFFF));
		add_row(byte_row(8'h01, 1'b1, 1'b0));
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(byte_row(8'h00, 1'b0, 1'b0));
		add_row(chk_row(8'h00, 1'b0, 1'b1, 2, K_ERR, 32'd0, ERR_MISMATCH));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with both sides at the first idle mix
		snd_idle_pct = 14;
		rcv_idle_pct = 62;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_REG) begin
				wait_idle();
				write_reg(row.idx, row.value);
			end else begin
				send_byte(row.data, row.start_flag, row.end_flag);
				if (row.chk) begin
					if (step_results.size() != row.n) begin
						$display("%0t: row %0d result count mismatch, expected %0d, actual %0d",
							$time, i, row.n, step_results.size());
						mismatches++;
					end else if (row.n > 0) begin
						tail = step_results[step_results.size() - 1];
						if (tail.kind != row.kind || tail.value != row.value ||
								tail.error_code != row.code) begin
							$display("%0t: row %0d mismatch, expected %0h/%0h/%0h, actual %0h/%0h/%0h",
								$time, i, row.kind, row.value, row.code,
								tail.kind, tail.value, tail.error_code);
							mismatches++;
						end
					end
				end
			end
		end

		// Random part: nine register settings, three idle mixes
		for (int p = 0; p < 9; p++) begin
			case (p / 3)
				0: begin
					snd_idle_pct = 14;
					rcv_idle_pct = 62;
				end
				1: begin
					snd_idle_pct = 62;
					rcv_idle_pct = 14;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (p)
				0: begin lay = 1'b0; comp = 1'b0; samples = 32'd0; end
				1: begin lay = 1'b0; comp = 1'b0; samples = 32'hFFFF_FFFF; end
				2: begin lay = 1'b1; comp = 1'b0; samples = 32'hFFFF_FFFF; end
				3: begin lay = 1'b0; comp = 1'b1; samples = $urandom(); end
				4: begin lay = 1'b1; comp = 1'b1; samples = 32'd0; end
				5: begin lay = 1'b0; comp = 1'b0; samples = $urandom(); end
				6: begin lay = 1'b1; comp = 1'b0; samples = $urandom(); end
				7: begin lay = 1'b0; comp = 1'b1; samples = 32'hFFFF_FFFF; end
				default: begin lay = 1'b0; comp = 1'b0; samples = $urandom_range(4, 1); end
			endcase
			// registers change only with nothing in flight
			wait_idle();
			write_reg(REG_LAYOUT, {31'd0, lay});
			write_reg(REG_COMP, {31'd0, comp});
			write_reg(REG_EXPECTED, samples);
			phase_count = 0;
			while (phase_count < 105) begin
				send_block(counted);
				phase_count += counted;
			end
		end

		// Drain, bounded, then allow for the output latency
		s_tvalid <= 1'b0;
		guard = 0;
		while (expected_fields.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (expected_fields.size() != 0) begin
			$display("%0t: %0d results missing, expected kind %0h next", $time,
				expected_fields.size(), expected_fields[0].kind);
			mismatches++;
		end

		$display("Ran %0d bytes (%0d random blocks over both layouts and compression modes),",
			bytes_sent, blocks_sent);
		$display("%0d register writes, %0d results compared, %0d mismatches.",
			reg_writes, results_checked, mismatches);
		if (mismatches == 0) begin
			$display("variant_header_byte_parser_unit_test: PASS");
		end else begin
			$display("variant_header_byte_parser_unit_test: FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/vhbp_pkg.sv
sv/variant_header_byte_parser_unit.sv
sv/vhbp_checker.sv
bench/variant_header_byte_parser_unit_test.sv
